// ===== rtl/page_bitmap_allocator_defines.svh =====
// Assertion macros for the checker file of the page bitmap allocator.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef PAGE_BITMAP_ALLOCATOR_DEFINES_SVH
`define PAGE_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, off while reset is low.
`define PBA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("page bitmap allocator check failed");

// Next-cycle implication, off while reset is low.
`define PBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("page bitmap allocator check failed");

`endif

// ===== rtl/pba_pkg.sv =====
// Shared types and constants of the page bitmap allocator.
// No dependencies; imported by every module of the block.
package pba_pkg;

    localparam int PAGES      = 1024;
    localparam int PAGE_BYTES = 4096;
    localparam int WORD_BITS  = 32;
    localparam int WORDS      = PAGES / WORD_BITS;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WORD_W     = $clog2(WORDS);
    localparam int PAGE_W     = $clog2(PAGES + 1);
    localparam int CNT_W      = BIT_W + 1;
    localparam int NW_W       = PAGE_W - BIT_W;
    localparam int ADDR_W     = 32;
    localparam int PIDX_W     = 10;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [WORD_BITS-1:0] FULL_WORD = '1;
    localparam logic [PAGE_W-1:0]    PAGES_C   = PAGE_W'(PAGES);

    // register index, taken from paddr[2]
    localparam logic REG_PAGE_COUNT = 1'b0;

    typedef enum logic [1:0] {
        KIND_MARK  = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_TEST  = 2'd2,
        KIND_FIND  = 2'd3
    } kind_t;

    typedef enum logic {
        UOP_SET = 1'b0,
        UOP_CLR = 1'b1
    } uop_t;

    typedef struct packed {
        kind_t              kind;
        logic [ADDR_W-1:0]  base_addr;
        logic [ADDR_W-1:0]  length_bytes;
        logic [PIDX_W-1:0]  page_index;
    } pba_in_t;

    typedef struct packed {
        logic               found;
        logic [PIDX_W-1:0]  free_page;
        logic               page_is_set;
        logic [PAGE_W-1:0]  pages_used;
        logic               range_error;
    } pba_out_t;

    // request to the shared word unit: bit range [lo, hi) and operation
    typedef struct packed {
        uop_t               op;
        logic [BIT_W-1:0]   lo;
        logic [CNT_W-1:0]   hi;
    } unit_req_t;

    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic               has_zero;
        logic [BIT_W-1:0]   zero_pos;
        logic               lo_bit;
    } unit_rsp_t;

endpackage

// ===== rtl/pba_word_unit.sv =====
// Shared bitmap word unit: range mask set or clear, lowest-zero search, bit test.
// Depends on pba_pkg.
module pba_word_unit import pba_pkg::*; (
    input  logic [WORD_BITS-1:0] word_in,
    input  unit_req_t            req,
    output logic [WORD_BITS-1:0] word_out,
    output unit_rsp_t            rsp
);

    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] mask;
    logic [CNT_W-1:0]     hi_shift;

    always_comb begin
        hi_shift = CNT_W'(WORD_BITS) - req.hi;
        lo_mask  = FULL_WORD << req.lo;
        hi_mask  = FULL_WORD >> hi_shift;
        mask     = lo_mask & hi_mask;
        case (req.op)
            UOP_SET: word_out = word_in | mask;
            UOP_CLR: word_out = word_in & ~mask;
            default: word_out = word_in;
        endcase
    end

    always_comb begin
        rsp.count    = req.hi - CNT_W'(req.lo);
        rsp.has_zero = ~&word_in;
        rsp.lo_bit   = word_in[req.lo];
        rsp.zero_pos = '0;
        // scan from the top so the lowest clear bit wins
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (!word_in[j]) begin
                rsp.zero_pos = BIT_W'(j);
            end
        end
    end

endmodule

// ===== rtl/page_bitmap_allocator.sv =====
// Page bitmap allocator: one bit per physical page, 32 pages to a bitmap word.
// Input channel s_valid/s_ready/s_data carries one request word (mark region, clear
// page, test page, find first free); m_valid/m_ready/m_data returns one result word
// per request. page_count is set over the APB-style port at address 0.
//
// Timing: s_ready is high only while the sequencer is idle, so one request is in
// work at a time. Clear and test go from the idle state to the done state and on
// to the output register. Mark region passes through the setup state and then the
// mark state, where the shared word unit sets one word per cycle for each bitmap
// word the region touches. Find first free scans one whole word below the limit
// per cycle, stopping at a word with a free page or after the last whole word.
// The next request is taken in the cycle after the result is loaded.
// A result sits in the output register until taken; the block takes a new request
// meanwhile, and a finished result waits in the sequencer if the register is full.
//
// Reset (aresetn low, synchronous) clears the whole bitmap, the used count and the
// output valid flag at once and sets page_count to 1024. No clearing pass follows.
module page_bitmap_allocator import pba_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pba_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pba_out_t           m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MARK,
        ST_FIND,
        ST_DONE
    } st_t;

    st_t                  state_reg, state_next;
    logic [WORD_BITS-1:0] bitmap_reg [WORDS];
    logic [PAGE_W-1:0]    page_count_reg;
    logic [PAGE_W-1:0]    used_reg, used_next;
    logic [ADDR_W-1:0]    start_reg, start_next;
    logic [ADDR_W:0]      end_reg, end_next;
    logic [PAGE_W-1:0]    pos_reg, pos_next;
    logic [PAGE_W-1:0]    stop_reg, stop_next;
    logic [NW_W-1:0]      find_idx_reg, find_idx_next;
    logic [NW_W-1:0]      nw_reg, nw_next;
    pba_out_t             res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    pba_out_t             m_data_reg, m_data_next;

    logic [PAGE_W-1:0]    limit;
    logic                 wr_en;
    logic [WORD_W-1:0]    wr_idx;
    logic [WORD_W-1:0]    rd_idx;
    logic [WORD_BITS-1:0] unit_out;
    unit_req_t            unit_req;
    unit_rsp_t            unit_rsp;
    logic [PAGE_W-1:0]    idx_ext;
    logic [PAGE_W-1:0]    word_base;
    logic [PAGE_W-1:0]    word_end;
    logic [PAGE_W-1:0]    seg_end;
    logic [ADDR_W:0]      limit_ext;
    logic [ADDR_W:0]      stop_wide;
    logic [PAGE_W:0]      used_sum;
    logic                 cfg_wr;

    pba_word_unit u_unit (
        .word_in  (bitmap_reg[rd_idx]),
        .req      (unit_req),
        .word_out (unit_out),
        .rsp      (unit_rsp)
    );

    assign limit     = (page_count_reg < PAGES_C) ? page_count_reg : PAGES_C;
    assign limit_ext = (ADDR_W + 1)'(limit);
    assign idx_ext   = PAGE_W'(s_data.page_index);
    assign word_base = {pos_reg[PAGE_W-1:BIT_W], BIT_W'(0)};
    assign word_end  = word_base + PAGE_W'(WORD_BITS);
    assign seg_end   = (stop_reg < word_end) ? stop_reg : word_end;
    assign used_sum  = (PAGE_W + 1)'(used_reg) + (PAGE_W + 1)'(unit_rsp.count);
    assign stop_wide = (end_reg < limit_ext) ? end_reg : limit_ext;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign pready  = 1'b1;
    assign prdata  = PDATA_W'(page_count_reg);
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_PAGE_COUNT);

    always_comb begin
        state_next    = state_reg;
        used_next     = used_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        pos_next      = pos_reg;
        stop_next     = stop_reg;
        find_idx_next = find_idx_reg;
        nw_next       = nw_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        wr_en         = 1'b0;
        wr_idx        = idx_ext[BIT_W +: WORD_W];
        rd_idx        = idx_ext[BIT_W +: WORD_W];
        unit_req.op   = UOP_SET;
        unit_req.lo   = idx_ext[BIT_W-1:0];
        unit_req.hi   = CNT_W'(idx_ext[BIT_W-1:0]) + CNT_W'(1);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_next = '0;
                    case (s_data.kind)
                        KIND_MARK: begin
                            start_next = s_data.base_addr / PAGE_BYTES;
                            end_next   = (ADDR_W + 1)'(s_data.base_addr / PAGE_BYTES)
                                       + (ADDR_W + 1)'(s_data.length_bytes / PAGE_BYTES);
                            state_next = ST_SETUP;
                        end
                        KIND_CLEAR, KIND_TEST: begin
                            unit_req.op = UOP_CLR;
                            if (idx_ext >= limit) begin
                                res_next.range_error = 1'b1;
                            end else if (s_data.kind == KIND_CLEAR) begin
                                wr_en = 1'b1;
                            end else begin
                                res_next.page_is_set = unit_rsp.lo_bit;
                            end
                            state_next = ST_DONE;
                        end
                        KIND_FIND: begin
                            find_idx_next = '0;
                            nw_next       = limit[PAGE_W-1:BIT_W];
                            state_next    = ST_FIND;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_SETUP: begin
                // a nonempty region that runs past the limit is an error
                res_next.range_error = (end_reg != (ADDR_W + 1)'(start_reg))
                                     && (end_reg > limit_ext);
                if ((ADDR_W + 1)'(start_reg) < stop_wide) begin
                    pos_next   = start_reg[PAGE_W-1:0];
                    stop_next  = stop_wide[PAGE_W-1:0];
                    state_next = ST_MARK;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_MARK: begin
                rd_idx      = pos_reg[BIT_W +: WORD_W];
                wr_idx      = pos_reg[BIT_W +: WORD_W];
                unit_req.op = UOP_SET;
                unit_req.lo = pos_reg[BIT_W-1:0];
                unit_req.hi = CNT_W'(seg_end - word_base);
                wr_en       = 1'b1;
                used_next   = (used_sum > (PAGE_W + 1)'(PAGES_C)) ? PAGES_C
                                                                  : used_sum[PAGE_W-1:0];
                pos_next    = seg_end;
                if (seg_end == stop_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_FIND: begin
                rd_idx = find_idx_reg[WORD_W-1:0];
                if (find_idx_reg == nw_reg) begin
                    state_next = ST_DONE;
                end else if (unit_rsp.has_zero) begin
                    res_next.found     = 1'b1;
                    res_next.free_page = PIDX_W'({find_idx_reg[WORD_W-1:0],
                                                  unit_rsp.zero_pos});
                    state_next         = ST_DONE;
                end else begin
                    find_idx_next = find_idx_reg + NW_W'(1);
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next            = res_reg;
                    m_data_next.pages_used = used_reg;
                    state_next             = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            m_valid_reg    <= 1'b0;
            page_count_reg <= PAGES_C;
            for (int i = 0; i < WORDS; i++) begin
                bitmap_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr) begin
                page_count_reg <= pwdata[PAGE_W-1:0];
            end
            if (wr_en) begin
                bitmap_reg[wr_idx] <= unit_out;
            end
        end
        start_reg    <= start_next;
        end_reg      <= end_next;
        pos_reg      <= pos_next;
        stop_reg     <= stop_next;
        find_idx_reg <= find_idx_next;
        nw_reg       <= nw_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

endmodule

// ===== rtl/pba_checker.sv =====
// Port-level checks for the page bitmap allocator, bound to the top level.
// Depends on pba_pkg and page_bitmap_allocator_defines.svh.
`include "page_bitmap_allocator_defines.svh"

module pba_checker import pba_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input pba_in_t            s_data,
    input logic               m_valid,
    input logic               m_ready,
    input pba_out_t           m_data,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [PDATA_W-1:0] pwdata,
    input logic [PDATA_W-1:0] prdata,
    input logic               pready
);

    // a stalled result word holds
    `PBA_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // one request in work at a time
    `PBA_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready)

    // used count saturates
    `PBA_ASSERT_NOW(a_used_sat, m_valid, m_data.pages_used <= PAGES_C)

    // free_page reads zero when nothing was found
    `PBA_ASSERT_NOW(a_free_zero, m_valid && !m_data.found, m_data.free_page == '0)

endmodule

bind page_bitmap_allocator pba_checker u_pba_checker (.*);
